// ===== hw/rtl/yuvmk_pkg.sv =====
// Types, constants and helpers for the YUYV to RGB converter with marker mask.
package yuvmk_pkg;

   localparam int DivStages       = 4;
   localparam int DivStepsPerStg  = 4;

   localparam logic signed [17:0] CoefVToR = 18'sd91881;
   localparam logic signed [17:0] CoefVToG = 18'sd46792;
   localparam logic signed [17:0] CoefUToG = 18'sd21889;
   localparam logic signed [17:0] CoefUToB = 18'sd116129;
   localparam logic [8:0]         ChromaBias = 9'd128;

   localparam logic [16:0] ResetRedShare   = 17'd42201;
   localparam logic [16:0] ResetGreenShare = 17'd14067;
   localparam logic [16:0] ResetBlueShare  = 17'd9267;
   localparam logic [33:0] ResetMaxDist    = 34'd134861043;
   localparam logic [7:0]  ResetFill       = 8'd15;

   typedef enum logic [2:0] {
      CSR_MARKER_RED,
      CSR_MARKER_GREEN,
      CSR_MARKER_BLUE,
      CSR_MAX_DIST,
      CSR_FILL_RED,
      CSR_FILL_GREEN,
      CSR_FILL_BLUE
   } csr_index_type;

   typedef struct packed {
      logic [7:0] blue;
      logic [7:0] green;
      logic [7:0] red;
   } rgb_type;

   typedef struct packed {
      logic    last;
      rgb_type second;
      rgb_type first;
   } pix_type;

   typedef struct packed {
      logic [9:0]  rem;
      logic [16:0] quo;
   } div_type;

   function automatic logic [7:0] clamp_chan(input logic signed [10:0] v);
      logic [7:0] o;
      if (v < 11'sd0) begin
         o = 8'd0;
      end else if (v > 11'sd255) begin
         o = 8'd255;
      end else begin
         o = v[7:0];
      end
      return o;
   endfunction

   function automatic rgb_type pixel_rgb(input logic [7:0] y,
                                         input logic signed [10:0] t_vr,
                                         input logic signed [10:0] t_vg,
                                         input logic signed [10:0] t_ug,
                                         input logic signed [10:0] t_ub);
      logic signed [10:0] ys;
      rgb_type            o;
      ys      = $signed({3'b000, y});
      o.red   = clamp_chan(ys + t_vr);
      o.green = clamp_chan(ys - t_vg - t_ug);
      o.blue  = clamp_chan(ys + t_ub);
      return o;
   endfunction

   // one restoring division step, quotient bit shifted in at the bottom
   function automatic div_type div_step(input div_type d, input logic [9:0] s);
      logic [10:0] r2;
      div_type     o;
      r2 = {d.rem, 1'b0};
      if (r2 >= {1'b0, s}) begin
         o.rem = 10'(r2 - {1'b0, s});
         o.quo = {d.quo[15:0], 1'b1};
      end else begin
         o.rem = r2[9:0];
         o.quo = {d.quo[15:0], 1'b0};
      end
      return o;
   endfunction

endpackage

// ===== hw/rtl/yuyv_to_rgb_marker_mask.sv =====
// YUYV macropixel to RGB888 converter with marker color mask, top level.
//
//  port group | dir | beat contents
//  req_       | in  | tdata: luma_first, chroma_blue, luma_second, chroma_red; tlast: in_last
//  rsp_       | out | tdata: first rgb, second rgb; tuser: is_marker; tlast: out_last
//  csr_       | in  | write enable, register index, 34-bit write data
//
//  One beat per cycle while the output is not stalled; req accept leads to rsp valid through the stage registers.
//  The chromaticity division is a 4-stage restoring divider, 4 quotient bits per stage.
//  The whole pipe advances when the output register is empty or taken; else it holds.
//  Reset clears the stage valid bits and loads the register defaults.
module yuyv_to_rgb_marker_mask (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // luma_first, chroma_blue, luma_second, chroma_red
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // red/green/blue_first, red/green/blue_second
   output logic        rsp_tuser,   // is_marker
   output logic        rsp_tlast,
   input  logic        csr_wr_en,
   input  logic [2:0]  csr_index,
   input  logic [33:0] csr_wdata
);
   import yuvmk_pkg::*;

   localparam int LastStage = 8;
   localparam int DivFirst  = 2;

   logic [16:0] marker_red_share_ff, marker_green_share_ff, marker_blue_share_ff;
   logic [33:0] max_square_distance_ff;
   logic [7:0]  fill_red_ff, fill_green_ff, fill_blue_ff;

   logic                 pipe_adv;
   logic [LastStage:0]   vld_ff;
   logic [LastStage:0]   vld_in;

   logic [7:0]           y0_ff, y1_ff;
   logic                 last0_ff;
   logic signed [8:0]    u_in, v_in;
   logic signed [26:0]   prod_vr_in, prod_vg_in, prod_ug_in, prod_ub_in;
   logic signed [26:0]   prod_vr_ff, prod_vg_ff, prod_ug_ff, prod_ub_ff;

   pix_type              pix_ff [LastStage:1];
   pix_type              pix1_in;

   logic [9:0]           s_ff   [DivStages:0];
   div_type              div_ff [DivStages:0][3];
   div_type              div_in [DivStages:0][3];
   logic [9:0]           s0_in;

   logic [16:0]          share [3];
   logic [16:0]          diff_in [3];
   logic [16:0]          diff_ff [3];
   logic                 szero7_ff, szero8_ff;
   logic [33:0]          sq_in [3];
   logic [33:0]          sq_ff [3];

   logic [35:0]          dist_in;
   logic                 hit_in;
   logic                 rsp_tvalid_ff, rsp_marker_ff, rsp_last_ff;
   logic [47:0]          rsp_data_ff;
   rgb_type              first_in;

   assign pipe_adv   = !rsp_tvalid_ff || rsp_tready;
   assign req_tready = pipe_adv;

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         marker_red_share_ff    <= ResetRedShare;
         marker_green_share_ff  <= ResetGreenShare;
         marker_blue_share_ff   <= ResetBlueShare;
         max_square_distance_ff <= ResetMaxDist;
         fill_red_ff            <= ResetFill;
         fill_green_ff          <= ResetFill;
         fill_blue_ff           <= ResetFill;
      end else if (csr_wr_en) begin
         case (csr_index_type'(csr_index))
            CSR_MARKER_RED:   marker_red_share_ff    <= csr_wdata[16:0];
            CSR_MARKER_GREEN: marker_green_share_ff  <= csr_wdata[16:0];
            CSR_MARKER_BLUE:  marker_blue_share_ff   <= csr_wdata[16:0];
            CSR_MAX_DIST:     max_square_distance_ff <= csr_wdata;
            CSR_FILL_RED:     fill_red_ff            <= csr_wdata[7:0];
            CSR_FILL_GREEN:   fill_green_ff          <= csr_wdata[7:0];
            CSR_FILL_BLUE:    fill_blue_ff           <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   assign vld_in = {vld_ff[LastStage-1:0], req_tvalid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff        <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else if (pipe_adv) begin
         vld_ff        <= vld_in;
         rsp_tvalid_ff <= vld_ff[LastStage];
      end
   end

   // stage 0: chroma products
   assign u_in       = $signed({1'b0, req_tdata[15:8]} - ChromaBias);
   assign v_in       = $signed({1'b0, req_tdata[31:24]} - ChromaBias);
   assign prod_vr_in = v_in * CoefVToR;
   assign prod_vg_in = v_in * CoefVToG;
   assign prod_ug_in = u_in * CoefUToG;
   assign prod_ub_in = u_in * CoefUToB;

   // stage 1: floor, add, clamp
   always_comb begin
      pix1_in.last   = last0_ff;
      pix1_in.first  = pixel_rgb(y0_ff, $signed(prod_vr_ff[26:16]),
                                 $signed(prod_vg_ff[26:16]), $signed(prod_ug_ff[26:16]),
                                 $signed(prod_ub_ff[26:16]));
      pix1_in.second = pixel_rgb(y1_ff, $signed(prod_vr_ff[26:16]),
                                 $signed(prod_vg_ff[26:16]), $signed(prod_ug_ff[26:16]),
                                 $signed(prod_ub_ff[26:16]));
   end

   // stage 2: divider setup, stages 3..6: 4 quotient bits each
   assign s0_in = {2'b00, pix_ff[1].first.red} + {2'b00, pix_ff[1].first.green}
                + {2'b00, pix_ff[1].first.blue};

   always_comb begin
      logic [9:0] c10 [3];
      logic       qtop;
      c10[0] = {2'b00, pix_ff[1].first.red};
      c10[1] = {2'b00, pix_ff[1].first.green};
      c10[2] = {2'b00, pix_ff[1].first.blue};
      for (int ch = 0; ch < 3; ch++) begin
         qtop = c10[ch] >= s0_in;
         div_in[0][ch].rem = qtop ? 10'(c10[ch] - s0_in) : c10[ch];
         div_in[0][ch].quo = {16'd0, qtop};
      end
      for (int k = 1; k <= DivStages; k++) begin
         for (int ch = 0; ch < 3; ch++) begin
            div_in[k][ch] = div_ff[k-1][ch];
            for (int st = 0; st < DivStepsPerStg; st++) begin
               div_in[k][ch] = div_step(div_in[k][ch], s_ff[k-1]);
            end
         end
      end
   end

   // stage 7: distance per channel, stage 8: squares
   assign share[0] = marker_red_share_ff;
   assign share[1] = marker_green_share_ff;
   assign share[2] = marker_blue_share_ff;

   always_comb begin
      for (int ch = 0; ch < 3; ch++) begin
         if (div_ff[DivStages][ch].quo >= share[ch]) begin
            diff_in[ch] = div_ff[DivStages][ch].quo - share[ch];
         end else begin
            diff_in[ch] = share[ch] - div_ff[DivStages][ch].quo;
         end
         sq_in[ch] = diff_ff[ch] * diff_ff[ch];
      end
   end

   // stage 9: sum, compare, select
   assign dist_in  = 36'(sq_ff[0]) + 36'(sq_ff[1]) + 36'(sq_ff[2]);
   assign hit_in   = !szero8_ff && (dist_in < {2'b00, max_square_distance_ff});
   assign first_in = hit_in ? pix_ff[LastStage].first
                            : rgb_type'({fill_blue_ff, fill_green_ff, fill_red_ff});

   always_ff @(posedge clock) begin
      if (pipe_adv) begin
         y0_ff      <= req_tdata[7:0];
         y1_ff      <= req_tdata[23:16];
         last0_ff   <= req_tlast;
         prod_vr_ff <= prod_vr_in;
         prod_vg_ff <= prod_vg_in;
         prod_ug_ff <= prod_ug_in;
         prod_ub_ff <= prod_ub_in;
         pix_ff[1]  <= pix1_in;
         for (int k = 2; k <= LastStage; k++) begin
            pix_ff[k] <= pix_ff[k-1];
         end
         s_ff[0] <= s0_in;
         for (int k = 1; k <= DivStages; k++) begin
            s_ff[k] <= s_ff[k-1];
         end
         for (int k = 0; k <= DivStages; k++) begin
            for (int ch = 0; ch < 3; ch++) begin
               div_ff[k][ch] <= div_in[k][ch];
            end
         end
         for (int ch = 0; ch < 3; ch++) begin
            diff_ff[ch] <= diff_in[ch];
            sq_ff[ch]   <= sq_in[ch];
         end
         szero7_ff     <= s_ff[DivStages] == 10'd0;
         szero8_ff     <= szero7_ff;
         rsp_data_ff   <= {pix_ff[LastStage].second, first_in};
         rsp_marker_ff <= hit_in;
         rsp_last_ff   <= pix_ff[LastStage].last;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_marker_ff;
   assign rsp_tlast  = rsp_last_ff;

   a_stall_freezes_pipe : assert property (@(posedge clock) disable iff (reset)
      !pipe_adv |=> $stable(vld_ff))
      else $error("stage valid bits moved during a stall");

   a_marker_not_black : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata[23:0] != 24'd0)
      else $error("black first pixel flagged as marker");

   a_div_rem_bound : assert property (@(posedge clock) disable iff (reset)
      vld_ff[DivFirst+DivStages] && s_ff[DivStages] != 10'd0 |->
         div_ff[DivStages][0].rem < s_ff[DivStages] &&
         div_ff[DivStages][1].rem < s_ff[DivStages] &&
         div_ff[DivStages][2].rem < s_ff[DivStages])
      else $error("divider remainder not below divisor");

   a_share_bound : assert property (@(posedge clock) disable iff (reset)
      vld_ff[DivFirst+DivStages] && s_ff[DivStages] != 10'd0 |->
         (!div_ff[DivStages][0].quo[16] || div_ff[DivStages][0].quo[15:0] == 16'd0) &&
         (!div_ff[DivStages][1].quo[16] || div_ff[DivStages][1].quo[15:0] == 16'd0) &&
         (!div_ff[DivStages][2].quo[16] || div_ff[DivStages][2].quo[15:0] == 16'd0))
      else $error("chromaticity share above one");

endmodule
